>>> sv/bal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types, widths and codes for the bounded array list.
// ----------------------------------------------------------------------------
package bal_pkg;

    // store geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // field widths
    localparam int MODE_W   = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 4;
    localparam int CAP_W    = 5;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // request codes
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } bal_state_t;

    // controller to datapath
    typedef struct packed {
        logic exec;         // run a non-search request and load the result
        logic scan_start;   // latch search key, clear scan pointer
        logic scan_adv;     // step scan pointer
        logic scan_finish;  // load search result
        logic scan_active;  // read port follows the scan pointer
    } bal_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_find;     // incoming word is a search
        logic scan_hit;     // current entry matches key
        logic scan_end;     // scan pointer reached the count
    } bal_stat_t;

endpackage

>>> sv/bounded_array_list_top.sv
`timescale 1ns / 1ps
// result: registered from the accepted word and valid the next cycle for all requests
//   but find; a find latches its key and scans to a match or the count first
// throughput: one request per cycle while results drain; a find holds off input
//   for its scan, one entry compared per cycle through the single read port
// reset: clears the entry count, sets capacity to 16, drops output valid;
//   stored entries are not cleared
// ----------------------------------------------------------------------------
// bounded_array_list_top
// Bounded list of signed 32-bit words with append, write, shift-down remove,
// read, find and clear requests.
// ----------------------------------------------------------------------------
module bounded_array_list_top import bal_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,     // capacity
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,       // mode[2:0], data_value[34:3], index[42:35]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata        // status[1:0], read_value[33:2],
                                            // found_index[37:34], count[42:38],
                                            // is_full[43], list_empty[44]
);

    bal_cmd_t  cmd;
    bal_stat_t stat;

    // sequencer
    bal_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and result
    bal_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    // reported count never exceeds the store
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[42:38] <= DEPTH_CNT))
        else $error("count above store depth");

    // one result load per cycle at most
    a_single_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.exec && cmd.scan_finish))
        else $error("request and search result loaded together");

    // no new word while a search is running
    a_scan_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_start |=> !s_tready)
        else $error("input ready during search");

    // a finished search always leaves a result pending
    a_scan_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_finish |=> m_tvalid)
        else $error("search result lost");

endmodule

>>> sv/bal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_ctrl
// Request sequencer: handshakes, search loop control and output valid.
// ----------------------------------------------------------------------------
module bal_ctrl import bal_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  bal_stat_t stat,
    output bal_cmd_t  cmd
);

    bal_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       scan_done;

    // input taken only when idle and the output slot frees up
    assign s_tready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign scan_done = stat.scan_hit || stat.scan_end;
    assign m_tvalid  = out_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && stat.req_find) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.exec       = accept && !stat.req_find;
                cmd.scan_start = accept && stat.req_find;
            end
            ST_SCAN: begin
                cmd.scan_active = 1'b1;
                cmd.scan_adv    = !scan_done;
                cmd.scan_finish = scan_done;
            end
            default: cmd = '0;
        endcase
    end

    // output word valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.exec || cmd.scan_finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/bal_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_dp
// Entry row with shift-down, length counter, capacity, search pointer and
// the registered result word.
// ----------------------------------------------------------------------------
module bal_dp import bal_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CAP_W-1:0]   cfg_wdata,
    input  logic [IN_W-1:0]    s_tdata,
    output logic [OUT_W-1:0]   m_tdata,
    input  bal_cmd_t           cmd,
    output bal_stat_t          stat
);

    logic [DATA_W-1:0]   entries_reg [DEPTH];
    logic [DATA_W-1:0]   entries_next [DEPTH];
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAP_W-1:0]    cap_reg;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic [DATA_W-1:0]   key_reg;

    logic [STATUS_W-1:0] out_status_reg, res_status;
    logic [DATA_W-1:0]   out_rd_reg, res_rd;
    logic [FIDX_W-1:0]   out_fi_reg, res_fi;
    logic [CNT_W-1:0]    out_count_reg;
    logic                out_full_reg, out_empty_reg;

    logic [MODE_W-1:0]   in_mode;
    logic [DATA_W-1:0]   in_value;
    logic [POS_W-1:0]    in_pos;
    logic [IDX_W-1:0]    pos_idx;
    logic                in_range;
    logic [CNT_W-1:0]    usable_cap;
    logic [IDX_W-1:0]    rd_addr;
    logic [DATA_W-1:0]   rd_data;
    logic                out_load;

    // unpack input word
    assign in_mode  = s_tdata[MODE_W-1:0];
    assign in_value = s_tdata[MODE_W +: DATA_W];
    assign in_pos   = s_tdata[MODE_W+DATA_W +: POS_W];
    assign pos_idx  = in_pos[IDX_W-1:0];
    assign in_range = in_pos < POS_W'(count_reg);

    // capacity clipped to store depth
    assign usable_cap = (CNT_W'(cap_reg) > DEPTH_CNT) ? DEPTH_CNT : CNT_W'(cap_reg);

    // single read port shared by position reads and the search
    assign rd_addr = cmd.scan_active ? scan_reg[IDX_W-1:0] : pos_idx;
    assign rd_data = entries_reg[rd_addr];

    // status to controller
    assign stat.req_find = (in_mode == MODE_FIND);
    assign stat.scan_end = scan_reg >= count_reg;
    assign stat.scan_hit = !stat.scan_end && (rd_data == key_reg);

    // request execution
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            entries_next[i] = entries_reg[i];
        end
        count_next = count_reg;
        res_status = ST_OK;
        res_rd     = '0;
        res_fi     = '0;
        if (cmd.exec) begin
            case (in_mode)
                MODE_APPEND: begin
                    if (count_reg >= usable_cap || count_reg >= DEPTH_CNT) begin
                        res_status = ST_FULL;
                    end else begin
                        entries_next[count_reg[IDX_W-1:0]] = in_value;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_WRITE: begin
                    if (in_range) begin
                        entries_next[pos_idx] = in_value;
                    end else begin
                        res_status = ST_RANGE;
                    end
                end
                MODE_REMOVE: begin
                    if (in_range) begin
                        // cells from the position to DEPTH-2 take their upper neighbor
                        for (int i = 0; i < DEPTH - 1; i++) begin
                            if (IDX_W'(i) >= pos_idx) begin
                                entries_next[i] = entries_reg[i + 1];
                            end
                        end
                        count_next = count_reg - 1'b1;
                    end else begin
                        res_status = ST_RANGE;
                    end
                end
                MODE_READ: begin
                    if (in_range) begin
                        res_rd = rd_data;
                    end else begin
                        res_status = ST_RANGE;
                    end
                end
                MODE_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    res_status = ST_OK;
                end
            endcase
        end else if (cmd.scan_finish) begin
            if (stat.scan_hit) begin
                res_fi = FIDX_W'(scan_reg[IDX_W-1:0]);
            end else begin
                res_status = ST_NOTFOUND;
            end
        end
    end

    // search pointer
    always_comb begin
        scan_next = scan_reg;
        if (cmd.scan_start) begin
            scan_next = '0;
        end else if (cmd.scan_adv) begin
            scan_next = scan_reg + 1'b1;
        end
    end

    assign out_load = cmd.exec || cmd.scan_finish;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end else begin
            count_reg <= count_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // entry row
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            entries_reg[i] <= entries_next[i];
        end
    end

    // search state and result word
    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        if (cmd.scan_start) begin
            key_reg <= in_value;
        end
        if (out_load) begin
            out_status_reg <= res_status;
            out_rd_reg     <= res_rd;
            out_fi_reg     <= res_fi;
            out_count_reg  <= count_next;
            out_full_reg   <= count_next >= usable_cap;
            out_empty_reg  <= count_next == '0;
        end
    end

    // pack result word
    assign m_tdata = {3'b000, out_empty_reg, out_full_reg, out_count_reg,
                      out_fi_reg, out_rd_reg, out_status_reg};

endmodule
